>>> rtl/core/lpl_pkg.sv
// Shared types and constants of the lookahead peak limiter.
package lpl_pkg;

  // Configuration port shape
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_ADDR_W = 2;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2,
    REG_LOOKAHEAD = 2'd3
  } cfg_idx_e;

  // Register values after reset
  localparam logic [15:0] THRESHOLD_RST = 16'd32440;
  localparam logic [16:0] ATTACK_RST    = 17'd655;
  localparam logic [16:0] RELEASE_RST   = 17'd32768;
  localparam logic [4:0]  LOOKAHEAD_RST = 5'd0;

  typedef struct packed {
    logic [15:0] threshold;
    logic [16:0] attack_coeff;
    logic [16:0] release_coeff;
    logic [4:0]  lookahead_delay;
  } cfg_t;

  // Unity gain in Q1.16
  localparam logic [16:0] UNITY = 17'h10000;

  // Quotient bits produced by the divider, one per cycle
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDST,
    S_PEAK,
    S_PADD,
    S_TGT,
    S_DIV,
    S_GMUL,
    S_GADD,
    S_OMUL,
    S_OUT
  } state_e;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_RDST,
    OP_PEAKMUL,
    OP_PEAKADD,
    OP_TGT,
    OP_DIVSTEP,
    OP_GAINMUL,
    OP_GAINADD,
    OP_OUTMUL,
    OP_OUTLOAD
  } dp_op_e;

  // Datapath status towards the controller
  typedef struct packed {
    logic clr_done;
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/lookahead_peak_limiter_top.sv
// Top level of the lookahead peak limiter.
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one request: a channel index and a
//    Q1.15 sample. Output channel (out_valid_o/out_ready_i) returns the limited sample
//    taken lookahead_delay positions back in that channel's delay line, with its index.
//  - Configuration writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at once; write
//    only while no request is in flight.
//  - From acceptance to out_valid_o a request passes the states RDST, PEAK, PADD, TGT,
//    GMUL, GADD, OMUL and OUT; the DIV steps are added between TGT and GMUL when a gain
//    target has to be divided out. The restoring divider (one quotient bit per cycle)
//    sets the longer path; the shared multiplier is used three times per request.
//  - A new request is not taken while one is being processed; the next request is taken as
//    soon as the current result sits in the output register.
//  - Reset: configuration returns to its defaults, and a clearing pass over all
//    NUM_CHANNELS*DELAY_MAX entries zeroes the delay store and resets the per-channel peak,
//    gain and write position; in_ready_o stays low during it.
//  - Receiver stall: the result holds in the output register; one further request is
//    processed and then waits until the register is free.
module lookahead_peak_limiter_top #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned DELAY_MAX    = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lpl_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [lpl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      chan_i,
  input  logic signed [15:0]              sample_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      out_chan_o,
  output logic signed [15:0]              sample_out_o
);

  lpl_pkg::cfg_t    cfg;
  lpl_pkg::dp_op_e  op;
  lpl_pkg::dp_sts_t sts;

  lpl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  lpl_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .DELAY_MAX    (DELAY_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .op_i         (op),
    .sts_o        (sts),
    .chan_i       (chan_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_chan_o   (out_chan_o),
    .sample_out_o (sample_out_o)
  );

endmodule

>>> rtl/core/lpl_cfg.sv
// Configuration register file of the lookahead peak limiter.
module lpl_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lpl_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [lpl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output lpl_pkg::cfg_t                    cfg_o
);

  lpl_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (lpl_pkg::cfg_idx_e'(cfg_addr_i))
        lpl_pkg::REG_THRESHOLD: cfg_d.threshold       = cfg_wdata_i[15:0];
        lpl_pkg::REG_ATTACK:    cfg_d.attack_coeff    = cfg_wdata_i;
        lpl_pkg::REG_RELEASE:   cfg_d.release_coeff   = cfg_wdata_i;
        lpl_pkg::REG_LOOKAHEAD: cfg_d.lookahead_delay = cfg_wdata_i[4:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold       <= lpl_pkg::THRESHOLD_RST;
      cfg_q.attack_coeff    <= lpl_pkg::ATTACK_RST;
      cfg_q.release_coeff   <= lpl_pkg::RELEASE_RST;
      cfg_q.lookahead_delay <= lpl_pkg::LOOKAHEAD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/lpl_ctrl.sv
// Sequencing state machine of the lookahead peak limiter.
module lpl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpl_pkg::dp_sts_t  sts_i,
  output lpl_pkg::dp_op_e   op_o
);

  lpl_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpl_pkg::S_CLEAR: if (sts_i.clr_done) state_d = lpl_pkg::S_IDLE;
      lpl_pkg::S_IDLE:  if (in_valid_i) state_d = lpl_pkg::S_RDST;
      lpl_pkg::S_RDST:  state_d = lpl_pkg::S_PEAK;
      lpl_pkg::S_PEAK:  state_d = lpl_pkg::S_PADD;
      lpl_pkg::S_PADD:  state_d = lpl_pkg::S_TGT;
      lpl_pkg::S_TGT:   state_d = sts_i.need_div ? lpl_pkg::S_DIV : lpl_pkg::S_GMUL;
      lpl_pkg::S_DIV:   if (sts_i.div_last) state_d = lpl_pkg::S_GMUL;
      lpl_pkg::S_GMUL:  state_d = lpl_pkg::S_GADD;
      lpl_pkg::S_GADD:  state_d = lpl_pkg::S_OMUL;
      lpl_pkg::S_OMUL:  state_d = lpl_pkg::S_OUT;
      lpl_pkg::S_OUT:   if (sts_i.out_free) state_d = lpl_pkg::S_IDLE;
      default:          state_d = lpl_pkg::S_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_ready_o = 1'b0;
    op_o       = lpl_pkg::OP_NONE;
    unique case (state_q)
      lpl_pkg::S_CLEAR: op_o = lpl_pkg::OP_CLEAR;
      lpl_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = lpl_pkg::OP_LOAD;
      end
      lpl_pkg::S_RDST:  op_o = lpl_pkg::OP_RDST;
      lpl_pkg::S_PEAK:  op_o = lpl_pkg::OP_PEAKMUL;
      lpl_pkg::S_PADD:  op_o = lpl_pkg::OP_PEAKADD;
      lpl_pkg::S_TGT:   op_o = lpl_pkg::OP_TGT;
      lpl_pkg::S_DIV:   op_o = lpl_pkg::OP_DIVSTEP;
      lpl_pkg::S_GMUL:  op_o = lpl_pkg::OP_GAINMUL;
      lpl_pkg::S_GADD:  op_o = lpl_pkg::OP_GAINADD;
      lpl_pkg::S_OMUL:  op_o = lpl_pkg::OP_OUTMUL;
      lpl_pkg::S_OUT:   if (sts_i.out_free) op_o = lpl_pkg::OP_OUTLOAD;
      default:          op_o = lpl_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpl_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/lpl_dp.sv
// Datapath of the lookahead peak limiter: channel state, delay store, multiplier, divider.
module lpl_dp #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned DELAY_MAX    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpl_pkg::cfg_t      cfg_i,
  input  lpl_pkg::dp_op_e    op_i,
  output lpl_pkg::dp_sts_t   sts_o,
  input  logic [2:0]         chan_i,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         out_chan_o,
  output logic signed [15:0] sample_out_o
);

  localparam int unsigned CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PW    = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
  localparam int unsigned TOTAL = NUM_CHANNELS * DELAY_MAX;
  localparam int unsigned AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned LW    = ((PW > 5) ? PW : 5) + 1;

  // Channel index folded into the implemented channels
  function automatic logic [CW-1:0] chan_mod(input logic [2:0] c);
    logic [6:0] v;
    v = {4'b0, c};
    for (int k = 0; k < 8; k++) begin
      if (v >= 7'(NUM_CHANNELS)) v = v - 7'(NUM_CHANNELS);
    end
    return v[CW-1:0];
  endfunction

  // Stores
  logic [15:0]        peak_mem [NUM_CHANNELS];
  logic [16:0]        gain_mem [NUM_CHANNELS];
  logic [PW-1:0]      wp_mem   [NUM_CHANNELS];
  logic signed [15:0] dl_mem   [TOTAL];

  // Registers
  logic [AW-1:0]          clr_q;
  logic                   out_valid_q;
  logic [2:0]             chan_q;
  logic [CW-1:0]          ch_q;
  logic signed [15:0]     x_q;
  logic [15:0]            st_peak_q;
  logic [16:0]            st_gain_q;
  logic [PW-1:0]          st_wp_q;
  logic signed [15:0]     dl_rdata_q;
  logic signed [35:0]     prod_q;
  logic [15:0]            peak_q;
  logic [16:0]            gain_q;
  logic [16:0]            target_q;
  logic [15:0]            rem_q;
  logic [lpl_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [2:0]             out_chan_q;
  logic signed [15:0]     sample_out_q;

  // Coefficients above one act as one
  logic [16:0] ca, cr;
  assign ca = (cfg_i.attack_coeff  > lpl_pkg::UNITY) ? lpl_pkg::UNITY : cfg_i.attack_coeff;
  assign cr = (cfg_i.release_coeff > lpl_pkg::UNITY) ? lpl_pkg::UNITY : cfg_i.release_coeff;

  // Sample magnitude, full scale negative gives 32768
  logic [15:0] mag;
  assign mag = x_q[15] ? (~x_q + 16'd1) : x_q;

  // Lookahead clamped into the store, read position behind the write position
  logic [LW-1:0] la_ext;
  logic [PW-1:0] dly;
  logic [PW:0]   rp_sum, rp_wrap;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp_next;
  always_comb begin
    la_ext  = LW'(cfg_i.lookahead_delay);
    dly     = (la_ext >= LW'(DELAY_MAX)) ? PW'(DELAY_MAX - 1) : la_ext[PW-1:0];
    rp_sum  = {1'b0, st_wp_q} + (PW+1)'(DELAY_MAX) - {1'b0, dly};
    rp_wrap = (rp_sum >= (PW+1)'(DELAY_MAX)) ? (rp_sum - (PW+1)'(DELAY_MAX)) : rp_sum;
    rp      = rp_wrap[PW-1:0];
    wp_next = (st_wp_q == PW'(DELAY_MAX - 1)) ? '0 : st_wp_q + PW'(1);
  end

  logic [AW-1:0] ch_base, dl_waddr, dl_raddr;
  assign ch_base  = AW'(ch_q) * AW'(DELAY_MAX);
  assign dl_waddr = (op_i == lpl_pkg::OP_CLEAR) ? clr_q : ch_base + AW'(st_wp_q);
  assign dl_raddr = ch_base + AW'(rp);

  // Shared multiplier operand select
  logic signed [17:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_i)
      lpl_pkg::OP_PEAKMUL: begin
        mul_a = $signed({1'b0, (mag > st_peak_q) ? ca : cr});
        mul_b = $signed({2'b0, mag}) - $signed({2'b0, st_peak_q});
      end
      lpl_pkg::OP_GAINMUL: begin
        mul_a = $signed({1'b0, (target_q < st_gain_q) ? ca : cr});
        mul_b = $signed({1'b0, target_q}) - $signed({1'b0, st_gain_q});
      end
      lpl_pkg::OP_OUTMUL: begin
        mul_a = $signed({1'b0, gain_q});
        mul_b = 18'(dl_rdata_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round half up: floor((prod + 32768) / 65536)
  logic signed [35:0] rnd_full;
  logic signed [17:0] rnd;
  logic signed [17:0] peak_sum, gain_sum;
  logic signed [15:0] res_sat;
  always_comb begin
    rnd_full = (prod_q + 36'sd32768) >>> 16;
    rnd      = rnd_full[17:0];
    peak_sum = $signed({2'b0, st_peak_q}) + rnd;
    gain_sum = $signed({1'b0, st_gain_q}) + rnd;
    if (rnd > 18'sd32767)       res_sat = 16'sh7fff;
    else if (rnd < -18'sd32768) res_sat = 16'sh8000;
    else                        res_sat = rnd[15:0];
  end

  // Divider step: one quotient bit of threshold/peak
  logic [16:0] div_t;
  logic        div_ge;
  assign div_t  = {rem_q, 1'b0};
  assign div_ge = div_t >= {1'b0, peak_q};

  // Status
  assign sts_o.clr_done = (clr_q == AW'(TOTAL - 1));
  assign sts_o.need_div = peak_q > cfg_i.threshold;
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Clearing sweep counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == lpl_pkg::OP_CLEAR && !sts_o.clr_done) clr_q <= clr_q + AW'(1);
      if (op_i == lpl_pkg::OP_OUTLOAD) out_valid_q <= 1'b1;
      else if (out_ready_i)            out_valid_q <= 1'b0;
    end
  end

  // Channel state store
  always_ff @(posedge clk_i) begin
    if (op_i == lpl_pkg::OP_CLEAR && ({1'b0, clr_q} < (AW+1)'(NUM_CHANNELS))) begin
      peak_mem[clr_q[CW-1:0]] <= '0;
      gain_mem[clr_q[CW-1:0]] <= lpl_pkg::UNITY;
      wp_mem[clr_q[CW-1:0]]   <= '0;
    end else if (op_i == lpl_pkg::OP_GAINADD) begin
      peak_mem[ch_q] <= peak_q;
      gain_mem[ch_q] <= gain_sum[16:0];
      wp_mem[ch_q]   <= wp_next;
    end
    if (op_i == lpl_pkg::OP_RDST) begin
      st_peak_q <= peak_mem[ch_q];
      st_gain_q <= gain_mem[ch_q];
      st_wp_q   <= wp_mem[ch_q];
    end
  end

  // Delay store
  always_ff @(posedge clk_i) begin
    if (op_i == lpl_pkg::OP_CLEAR)        dl_mem[dl_waddr] <= '0;
    else if (op_i == lpl_pkg::OP_PEAKMUL) dl_mem[dl_waddr] <= x_q;
    if (op_i == lpl_pkg::OP_PEAKADD) dl_rdata_q <= dl_mem[dl_raddr];
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      lpl_pkg::OP_LOAD: begin
        chan_q <= chan_i;
        ch_q   <= chan_mod(chan_i);
        x_q    <= sample_in_i;
      end
      lpl_pkg::OP_PEAKMUL, lpl_pkg::OP_GAINMUL, lpl_pkg::OP_OUTMUL: begin
        prod_q <= mul_a * mul_b;
      end
      lpl_pkg::OP_PEAKADD: peak_q <= peak_sum[15:0];
      lpl_pkg::OP_TGT: begin
        rem_q    <= cfg_i.threshold;
        cnt_q    <= lpl_pkg::DIV_CNT_W'(lpl_pkg::DIV_STEPS - 1);
        target_q <= sts_o.need_div ? 17'd0 : lpl_pkg::UNITY;
      end
      lpl_pkg::OP_DIVSTEP: begin
        rem_q    <= div_ge ? 16'(div_t - {1'b0, peak_q}) : div_t[15:0];
        target_q <= {1'b0, target_q[14:0], div_ge};
        cnt_q    <= cnt_q - lpl_pkg::DIV_CNT_W'(1);
      end
      lpl_pkg::OP_GAINADD: gain_q <= gain_sum[16:0];
      lpl_pkg::OP_OUTLOAD: begin
        out_chan_q   <= chan_q;
        sample_out_q <= res_sat;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_chan_o   = out_chan_q;
  assign sample_out_o = sample_out_q;

endmodule
